### rtl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`timescale 1ns / 1ps

package u8sd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 31;
  localparam int unsigned CntW  = 3;
  localparam int unsigned ContW = 6;

  // Largest count of octets still due after a lead byte (six-octet form).
  localparam logic [CntW-1:0] MaxRemaining = 3'd5;

  // Decoder state carried from byte to byte.
  typedef struct packed {
    logic [CntW-1:0] bytes_remaining;
    logic [CpW-1:0]  accumulator;
  } u8sd_state_t;

  // One decode result for a byte.
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           invalid;
  } u8sd_result_t;

endpackage

### rtl/u8sd_step.sv
// Combinational decode of one byte against the current decoder state.
`timescale 1ns / 1ps

module u8sd_step import u8sd_pkg::*; (
  input  logic [ByteW-1:0] byte_i,
  input  u8sd_state_t      state_i,
  output u8sd_state_t      state_o,
  output u8sd_result_t     result_o
);

  logic [CpW-1:0] shifted;

  // Continuation path: shift in six payload bits, keep the low 31 bits.
  assign shifted = {state_i.accumulator[CpW-ContW-1:0], byte_i[ContW-1:0]};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.bytes_remaining != '0) begin
      // Inside a sequence: every byte is taken as a continuation.
      state_o.accumulator     = shifted;
      state_o.bytes_remaining = state_i.bytes_remaining - 3'd1;
      if (state_i.bytes_remaining == 3'd1) begin
        result_o.valid      = 1'b1;
        result_o.code_point = shifted;
      end
    end else begin
      // No sequence open: classify the byte as ASCII, lead or invalid.
      casez (byte_i)
        8'b0???_????: begin
          result_o.valid      = 1'b1;
          result_o.code_point = {{(CpW-ByteW){1'b0}}, byte_i};
        end
        8'b110?_????: begin
          state_o.accumulator     = {{(CpW-5){1'b0}}, byte_i[4:0]};
          state_o.bytes_remaining = 3'd1;
        end
        8'b1110_????: begin
          state_o.accumulator     = {{(CpW-4){1'b0}}, byte_i[3:0]};
          state_o.bytes_remaining = 3'd2;
        end
        8'b1111_0???: begin
          state_o.accumulator     = {{(CpW-3){1'b0}}, byte_i[2:0]};
          state_o.bytes_remaining = 3'd3;
        end
        8'b1111_10??: begin
          state_o.accumulator     = {{(CpW-2){1'b0}}, byte_i[1:0]};
          state_o.bytes_remaining = 3'd4;
        end
        8'b1111_110?: begin
          state_o.accumulator     = {{(CpW-1){1'b0}}, byte_i[0]};
          state_o.bytes_remaining = MaxRemaining;
        end
        default: begin
          // Stray continuation byte, 0xFE or 0xFF.
          result_o.valid   = 1'b1;
          result_o.invalid = 1'b1;
        end
      endcase
    end
  end

endmodule

### rtl/utf8_stream_decoder_unit.sv
// Input transfer reaches the result through the input register and then the result register.
// Throughput: one byte per cycle while the result register is empty or being read.
// Bytes that open or continue a sequence give no result; the completing byte gives one.
// The input register holds one byte while a result waits, so input stalls only when both are full.
// Reset (rst_n low, synchronous) clears valids and closes any open sequence.
`timescale 1ns / 1ps

module utf8_stream_decoder_unit import u8sd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [ByteW-1:0] in_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [CpW-1:0]   out_code_point,
  output logic             out_invalid
);

  logic             s1_valid_r;
  logic [ByteW-1:0] s1_byte_r;
  u8sd_state_t      state_r;
  u8sd_state_t      state_nxt;
  u8sd_result_t     res_nxt;
  logic             out_valid_r;
  logic [CpW-1:0]   out_code_point_r;
  logic             out_invalid_r;
  logic             advance;
  logic             consume;

  // The result register can take a new value when empty or being read.
  assign advance  = !out_valid_r || !out_stall;
  assign consume  = s1_valid_r && advance;
  assign in_stall = s1_valid_r && !advance;

  u8sd_step u_step (
    .byte_i   (s1_byte_r),
    .state_i  (state_r),
    .state_o  (state_nxt),
    .result_o (res_nxt)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_byte;
    end
  end

  // Decoder state advances once per consumed byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (consume) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= consume && res_nxt.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && consume && res_nxt.valid) begin
      out_code_point_r <= res_nxt.code_point;
      out_invalid_r    <= res_nxt.invalid;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_code_point = out_code_point_r;
  assign out_invalid    = out_invalid_r;

  // An invalid result always carries a zero code point.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_invalid_r |-> out_code_point_r == '0)
    else $error("invalid result with nonzero code point");

  // The open-sequence count never exceeds the six-octet form.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.bytes_remaining <= MaxRemaining)
    else $error("bytes_remaining out of range");

  // A consumed byte inside a sequence counts the sequence down by one.
  assert property (@(posedge clk) disable iff (!rst_n)
    consume && state_r.bytes_remaining != '0 |=>
      state_r.bytes_remaining == $past(state_r.bytes_remaining) - 3'd1)
    else $error("sequence count did not step down");

  // Input stalls only while the input register holds a byte and a result waits.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with free space");

endmodule
